### src/oil_pkg.sv
// oil_pkg: shared types and constants for the ordered item list unit
// field widths, operation and result codes, controller/datapath command
// and status structs; no dependencies
package oil_pkg;

  // payload field widths
  localparam int OP_W        = 2;
  localparam int IN_ITEM_W   = 32;
  localparam int POS_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int OUT_ITEM_W  = 32;
  localparam int COUNT_OUT_W = 5;

  // request operation codes; the fourth code is unused and falls to default arms
  typedef enum logic [OP_W-1:0] {
    OPC_APPEND = 2'd0,
    OPC_GET    = 2'd1,
    OPC_REMOVE = 2'd2
  } op_code_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_FULL      = 2'd2
  } res_code_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GET_WAIT,
    S_SCAN,
    S_DONE
  } ctrl_state_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_APPEND,
    DP_FULL,
    DP_MISS,
    DP_GET_RD,
    DP_GET_DONE,
    DP_SCAN_START,
    DP_SCAN_STEP,
    DP_SCAN_END
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_code_t req_op;
    logic     full;
    logic     pos_ok;
    logic     empty;
    logic     more;
    logic     out_free;
  } dp_stat_t;

endpackage

### src/oil_if.sv
// oil_in_if / oil_out_if: valid/ready channels of the ordered item list unit
// depends on oil_pkg for the field widths
interface oil_in_if;
  logic                            valid;
  logic                            ready;
  logic [oil_pkg::OP_W-1:0]        operation;
  logic [oil_pkg::IN_ITEM_W-1:0]   item_value;
  logic [oil_pkg::POS_W-1:0]       position;

  modport source (output valid, operation, item_value, position, input ready);
  modport sink   (input valid, operation, item_value, position, output ready);
endinterface

interface oil_out_if;
  logic                            valid;
  logic                            ready;
  logic [oil_pkg::STATUS_W-1:0]    status;
  logic [oil_pkg::OUT_ITEM_W-1:0]  item_out;
  logic [oil_pkg::COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, status, item_out, entry_count, input ready);
  modport sink   (input valid, status, item_out, entry_count, output ready);
endinterface

### src/oil_ctrl.sv
// oil_ctrl: sequencing state machine of the ordered item list unit
// drives datapath commands from datapath status; depends on oil_pkg
module oil_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  oil_pkg::dp_stat_t  stat,
  output oil_pkg::ctrl_cmd_t cmd
);

  oil_pkg::ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oil_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.op       = oil_pkg::DP_NONE;
    cmd.out_load = 1'b0;
    unique case (state_r)
      oil_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = oil_pkg::DP_LOAD;
          state_nxt = oil_pkg::S_EXEC;
        end
      end
      oil_pkg::S_EXEC: begin
        unique case (stat.req_op)
          oil_pkg::OPC_APPEND: begin
            cmd.op    = stat.full ? oil_pkg::DP_FULL : oil_pkg::DP_APPEND;
            state_nxt = oil_pkg::S_DONE;
          end
          oil_pkg::OPC_GET: begin
            if (stat.pos_ok) begin
              cmd.op    = oil_pkg::DP_GET_RD;
              state_nxt = oil_pkg::S_GET_WAIT;
            end else begin
              cmd.op    = oil_pkg::DP_MISS;
              state_nxt = oil_pkg::S_DONE;
            end
          end
          oil_pkg::OPC_REMOVE: begin
            if (stat.empty) begin
              cmd.op    = oil_pkg::DP_MISS;
              state_nxt = oil_pkg::S_DONE;
            end else begin
              cmd.op    = oil_pkg::DP_SCAN_START;
              state_nxt = oil_pkg::S_SCAN;
            end
          end
          default: begin
            cmd.op    = oil_pkg::DP_MISS;
            state_nxt = oil_pkg::S_DONE;
          end
        endcase
      end
      oil_pkg::S_GET_WAIT: begin
        cmd.op    = oil_pkg::DP_GET_DONE;
        state_nxt = oil_pkg::S_DONE;
      end
      oil_pkg::S_SCAN: begin
        if (stat.more) begin
          cmd.op = oil_pkg::DP_SCAN_STEP;
        end else begin
          cmd.op    = oil_pkg::DP_SCAN_END;
          state_nxt = oil_pkg::S_DONE;
        end
      end
      oil_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = oil_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = oil_pkg::S_IDLE;
      end
    endcase
  end

  // an accepted request always goes to decode
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == oil_pkg::S_EXEC)
    else $error("accepted request did not move to decode");

  // a result is only handed to the output register from the done state, which then returns to idle
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> state_r == oil_pkg::S_IDLE)
    else $error("output load did not return to idle");

  // a scan step never runs on an empty list
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == oil_pkg::DP_SCAN_STEP |-> !stat.empty)
    else $error("scan step on an empty list");

endmodule

### src/oil_dpath.sv
// oil_dpath: entry memory, count, scan index and result registers
// of the ordered item list unit; depends on oil_pkg
module oil_dpath #(
  parameter int CAPACITY   = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  oil_pkg::ctrl_cmd_t              cmd,
  output oil_pkg::dp_stat_t               stat,
  input  logic [oil_pkg::OP_W-1:0]        in_operation,
  input  logic [oil_pkg::IN_ITEM_W-1:0]   in_item_value,
  input  logic [oil_pkg::POS_W-1:0]       in_position,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [oil_pkg::STATUS_W-1:0]    out_status,
  output logic [oil_pkg::OUT_ITEM_W-1:0]  out_item_out,
  output logic [oil_pkg::COUNT_OUT_W-1:0] out_entry_count
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW  = oil_pkg::POS_W;
  localparam int OIW = oil_pkg::OUT_ITEM_W;
  localparam int OCW = oil_pkg::COUNT_OUT_W;

  // entry store
  logic [ITEM_WIDTH-1:0] mem [CAPACITY];
  logic [ITEM_WIDTH-1:0] rdata_r;

  oil_pkg::op_code_t     op_r, op_nxt;
  logic [ITEM_WIDTH-1:0] item_r, item_nxt;
  logic [PW-1:0]         pos_r, pos_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic                  found_r, found_nxt;
  oil_pkg::res_code_t    res_status_r, res_status_nxt;
  logic [ITEM_WIDTH-1:0] res_item_r, res_item_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [oil_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [OIW-1:0]        out_item_r, out_item_nxt;
  logic [OCW-1:0]        out_count_r, out_count_nxt;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [ITEM_WIDTH-1:0] wr_data;
  logic                  match;
  logic                  found_now;

  assign match     = (rdata_r == item_r);
  assign found_now = found_r | match;

  // status towards the controller
  assign stat.req_op   = op_r;
  assign stat.full     = (count_r >= CW'(CAPACITY));
  assign stat.pos_ok   = ((PW + CW)'(pos_r) < (PW + CW)'(count_r));
  assign stat.empty    = (count_r == '0);
  assign stat.more     = ((CW'(idx_r) + CW'(1)) < count_r);
  assign stat.out_free = !out_valid_r || out_ready;

  // per-operation datapath actions
  always_comb begin
    op_nxt         = op_r;
    item_nxt       = item_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_item_nxt   = res_item_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r - AW'(1);
    wr_data        = rdata_r;
    unique case (cmd.op)
      oil_pkg::DP_NONE: begin
      end
      oil_pkg::DP_LOAD: begin
        op_nxt   = oil_pkg::op_code_t'(in_operation);
        item_nxt = ITEM_WIDTH'(in_item_value);
        pos_nxt  = in_position;
      end
      oil_pkg::DP_APPEND: begin
        wr_en          = 1'b1;
        wr_addr        = count_r[AW-1:0];
        wr_data        = item_r;
        count_nxt      = count_r + CW'(1);
        res_status_nxt = oil_pkg::RES_OK;
        res_item_nxt   = '0;
      end
      oil_pkg::DP_FULL: begin
        res_status_nxt = oil_pkg::RES_FULL;
        res_item_nxt   = '0;
      end
      oil_pkg::DP_MISS: begin
        res_status_nxt = oil_pkg::RES_NOT_FOUND;
        res_item_nxt   = '0;
      end
      oil_pkg::DP_GET_RD: begin
        rd_en   = 1'b1;
        rd_addr = pos_r[AW-1:0];
      end
      oil_pkg::DP_GET_DONE: begin
        res_status_nxt = oil_pkg::RES_OK;
        res_item_nxt   = rdata_r;
      end
      oil_pkg::DP_SCAN_START: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        idx_nxt   = '0;
        found_nxt = 1'b0;
      end
      oil_pkg::DP_SCAN_STEP: begin
        // once matched, every later entry moves down by one
        wr_en     = found_r;
        found_nxt = found_now;
        rd_en     = 1'b1;
        rd_addr   = idx_r + AW'(1);
        idx_nxt   = idx_r + AW'(1);
      end
      oil_pkg::DP_SCAN_END: begin
        wr_en          = found_r;
        found_nxt      = found_now;
        res_item_nxt   = '0;
        if (found_now) begin
          count_nxt      = count_r - CW'(1);
          res_status_nxt = oil_pkg::RES_OK;
        end else begin
          res_status_nxt = oil_pkg::RES_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // output register, parted from the engine
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_count_nxt  = out_count_r;
    if (cmd.out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_item_nxt   = OIW'(res_item_r);
      out_count_nxt  = OCW'(count_r);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    item_r       <= item_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    found_r      <= found_nxt;
    res_status_r <= res_status_nxt;
    res_item_r   <= res_item_nxt;
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_item_out    = out_item_r;
  assign out_entry_count = out_count_r;

  // the count never goes past capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // an append grows the list by exactly one
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == oil_pkg::DP_APPEND |=> count_r == $past(count_r) + CW'(1))
    else $error("append did not advance the count");

  // a result is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

endmodule

### src/ordered_item_list_unit.sv
// Ordered item list unit: a bounded list of item handles kept in insertion
// order, with append, get by index and remove-first-match operations. One
// request is worked at a time: it is decoded in S_EXEC, a get then waits in
// S_GET_WAIT for the registered read, a remove scans in S_SCAN, and every
// request ends in S_DONE, which loads the result once the output register is
// free. Remove streams the stored entries through the single registered read
// port of the entry memory, one per cycle, comparing each and moving every
// later entry down by one through the write port in the same pass. The unit
// is ready for the next request as the result enters the output register,
// which holds it until it is taken. No clearing pass is needed after reset.
// depends on oil_pkg, oil_if, oil_ctrl and oil_dpath
module ordered_item_list_unit #(
  parameter int CAPACITY   = 16,
  parameter int ITEM_WIDTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  oil_in_if.sink    in_req,
  oil_out_if.source out_res
);

  oil_pkg::ctrl_cmd_t cmd;
  oil_pkg::dp_stat_t  stat;
  logic               in_ready;

  assign in_req.ready = in_ready;

  // sequencing
  oil_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and result path
  oil_dpath #(
    .CAPACITY   (CAPACITY),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (in_req.operation),
    .in_item_value   (in_req.item_value),
    .in_position     (in_req.position),
    .out_ready       (out_res.ready),
    .out_valid       (out_res.valid),
    .out_status      (out_res.status),
    .out_item_out    (out_res.item_out),
    .out_entry_count (out_res.entry_count)
  );

endmodule

### test/tb_ordered_item_list_unit.sv
`timescale 1ns / 100ps
// tb_ordered_item_list_unit: directed table and random requests against a list predictor
// depends on oil_pkg, oil_if and ordered_item_list_unit
module tb_ordered_item_list_unit;

  localparam int CAPACITY = 16;
  localparam int ITEM_W   = 32;
  localparam int POS_W    = oil_pkg::POS_W;
  localparam int CNT_W    = oil_pkg::COUNT_OUT_W;
  localparam int N_RANDOM = 1950;

  // the fourth operation code, which the unit treats as a miss
  localparam logic [oil_pkg::OP_W-1:0] OPC_UNUSED = 2'd3;

  typedef struct packed {
    oil_pkg::res_code_t                status;
    logic [oil_pkg::OUT_ITEM_W-1:0]    item;
    logic [oil_pkg::COUNT_OUT_W-1:0]   count;
  } list_res_t;

  typedef struct {
    logic [oil_pkg::OP_W-1:0]      op;
    logic [oil_pkg::IN_ITEM_W-1:0] val;
    logic [oil_pkg::POS_W-1:0]     pos;
    int                            reps;
    bit                            typed;
    list_res_t                     res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  oil_in_if  in_ch();
  oil_out_if out_ch();

  // predictor state and results still owed by the unit
  logic [ITEM_W-1:0] stored_items[$];
  list_res_t         pending_res[$];
  int                err_cnt;
  int                accepted_cnt;

  ordered_item_list_unit #(
    .CAPACITY  (CAPACITY),
    .ITEM_WIDTH(ITEM_W)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_ch),
    .out_res(out_ch)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // list behaviour: apply one request and return what the unit should answer
  function automatic list_res_t apply_list_op(logic [oil_pkg::OP_W-1:0] op,
                                              logic [oil_pkg::IN_ITEM_W-1:0] val,
                                              logic [oil_pkg::POS_W-1:0] pos);
    list_res_t r;
    int        hit;
    int        i;
    r.status = oil_pkg::RES_NOT_FOUND;
    r.item   = '0;
    hit      = -1;
    case (op)
      oil_pkg::OPC_APPEND: begin
        if (stored_items.size() >= CAPACITY) begin
          r.status = oil_pkg::RES_FULL;
        end else begin
          stored_items.push_back(val[ITEM_W-1:0]);
          r.status = oil_pkg::RES_OK;
        end
      end
      oil_pkg::OPC_GET: begin
        if (pos < stored_items.size()) begin
          r.status = oil_pkg::RES_OK;
          r.item   = stored_items[pos];
        end
      end
      oil_pkg::OPC_REMOVE: begin
        for (i = 0; i < stored_items.size(); i++) begin
          if (hit < 0 && stored_items[i] == val[ITEM_W-1:0]) hit = i;
        end
        if (hit >= 0) begin
          stored_items.delete(hit);
          r.status = oil_pkg::RES_OK;
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(stored_items.size());
    return r;
  endfunction

  // offer one request from the falling edge and hold it until taken
  task automatic send_req(input logic [oil_pkg::OP_W-1:0] op,
                          input logic [oil_pkg::IN_ITEM_W-1:0] val,
                          input logic [oil_pkg::POS_W-1:0] pos, input bit typed,
                          input list_res_t typed_res);
    list_res_t pred;
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.operation  = op;
    in_ch.item_value = val;
    in_ch.position   = pos;
    do @(posedge clk); while (!in_ch.ready);
    pred = apply_list_op(op, val, pos);
    pending_res.push_back(typed ? typed_res : pred);
    accepted_cnt++;
  endtask

  // drop valid and leave the sender idle; nothing happens when n is zero
  task automatic idle_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result checker
  always @(posedge clk) begin : res_check
    list_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: result with no request owed: status %0d item %h count %0d",
                 $time, out_ch.status, out_ch.item_out, out_ch.entry_count);
        err_cnt++;
      end else begin
        want = pending_res.pop_front();
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_ch.status);
          err_cnt++;
        end
        if (out_ch.item_out !== want.item) begin
          $display("%0t: item_out expected %h actual %h", $time, want.item, out_ch.item_out);
          err_cnt++;
        end
        if (out_ch.entry_count !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   out_ch.entry_count);
          err_cnt++;
        end
      end
    end
  end

  // result side: random ready, one long hold-off to back the unit up
  initial begin : res_ready
    bit hold_done;
    int r;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      r = $urandom_range(0, 99);
      if (!hold_done && accepted_cnt > 600) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (299) @(negedge clk);
        hold_done = 1'b1;
      end else if (r < 50) begin
        @(negedge clk);
        out_ch.ready = 1'b1;
        repeat ($urandom_range(0, 19)) @(negedge clk);
      end else if (r < 60) begin
        @(negedge clk);
        out_ch.ready = 1'b1;
        repeat ($urandom_range(40, 80)) @(negedge clk);
      end else if (r < 92) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat ($urandom_range(5, 30)) @(negedge clk);
      end
    end
  end

  // timeout
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // reset, directed table, random requests, drain
  initial begin : stim
    dir_row_t  dir_tab[$];
    list_res_t no_res;
    logic [oil_pkg::OP_W-1:0]      op;
    logic [oil_pkg::IN_ITEM_W-1:0] val;
    logic [oil_pkg::POS_W-1:0]     pos;
    bit fill_phase;
    bit no_gaps;
    int r;
    int k;
    int n;

    err_cnt          = 0;
    accepted_cnt     = 0;
    no_res           = '{oil_pkg::RES_OK, '0, '0};
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = oil_pkg::OPC_APPEND;
    in_ch.item_value = '0;
    in_ch.position   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty list, extremes, full list, removal with shift, duplicates
    dir_tab = '{
      '{oil_pkg::OPC_GET,    32'h0,        16'h0,    1,  1'b1,
        '{oil_pkg::RES_NOT_FOUND, 32'h0, 5'd0}},
      '{oil_pkg::OPC_REMOVE, 32'h0,        16'h0,    1,  1'b1,
        '{oil_pkg::RES_NOT_FOUND, 32'h0, 5'd0}},
      '{OPC_UNUSED,          32'hFFFFFFFF, 16'hFFFF, 1,  1'b1,
        '{oil_pkg::RES_NOT_FOUND, 32'h0, 5'd0}},
      '{oil_pkg::OPC_APPEND, 32'hFFFFFFFF, 16'hFFFF, 1,  1'b1,
        '{oil_pkg::RES_OK,        32'h0, 5'd1}},
      '{oil_pkg::OPC_APPEND, 32'h0,        16'h0,    1,  1'b1,
        '{oil_pkg::RES_OK,        32'h0, 5'd2}},
      '{oil_pkg::OPC_GET,    32'h0,        16'h0,    1,  1'b1,
        '{oil_pkg::RES_OK, 32'hFFFFFFFF, 5'd2}},
      '{oil_pkg::OPC_GET,    32'hFFFFFFFF, 16'h1,    1,  1'b1,
        '{oil_pkg::RES_OK,        32'h0, 5'd2}},
      '{oil_pkg::OPC_GET,    32'h0,        16'hFFFF, 1,  1'b1,
        '{oil_pkg::RES_NOT_FOUND, 32'h0, 5'd2}},
      '{oil_pkg::OPC_GET,    32'h0,        16'h2,    1,  1'b1,
        '{oil_pkg::RES_NOT_FOUND, 32'h0, 5'd2}},
      '{oil_pkg::OPC_APPEND, 32'h5A5A0000, 16'h0,    14, 1'b0, no_res},
      '{oil_pkg::OPC_APPEND, 32'h12345678, 16'h0,    1,  1'b1,
        '{oil_pkg::RES_FULL,      32'h0, 5'd16}},
      '{oil_pkg::OPC_GET,    32'h0,        16'd15,   1,  1'b0, no_res},
      '{oil_pkg::OPC_GET,    32'h0,        16'd16,   1,  1'b1,
        '{oil_pkg::RES_NOT_FOUND, 32'h0, 5'd16}},
      '{oil_pkg::OPC_REMOVE, 32'hFFFFFFFF, 16'h0,    1,  1'b1,
        '{oil_pkg::RES_OK,        32'h0, 5'd15}},
      '{oil_pkg::OPC_GET,    32'h0,        16'h0,    1,  1'b1,
        '{oil_pkg::RES_OK,        32'h0, 5'd15}},
      '{oil_pkg::OPC_REMOVE, 32'h5A5A000D, 16'h0,    1,  1'b1,
        '{oil_pkg::RES_OK,        32'h0, 5'd14}},
      '{oil_pkg::OPC_REMOVE, 32'h12345678, 16'h0,    1,  1'b1,
        '{oil_pkg::RES_NOT_FOUND, 32'h0, 5'd14}},
      '{oil_pkg::OPC_APPEND, 32'h5A5A0003, 16'h0,    1,  1'b1,
        '{oil_pkg::RES_OK,        32'h0, 5'd15}},
      '{oil_pkg::OPC_REMOVE, 32'h5A5A0003, 16'h0,    1,  1'b1,
        '{oil_pkg::RES_OK,        32'h0, 5'd14}},
      '{oil_pkg::OPC_GET,    32'h0,        16'd4,    1,  1'b0, no_res},
      '{oil_pkg::OPC_GET,    32'h0,        16'd13,   1,  1'b0, no_res},
      '{OPC_UNUSED,          32'h0,        16'h0,    1,  1'b1,
        '{oil_pkg::RES_NOT_FOUND, 32'h0, 5'd14}}
    };
    foreach (dir_tab[i]) begin
      for (k = 0; k < dir_tab[i].reps; k++) begin
        send_req(dir_tab[i].op, dir_tab[i].val + k, dir_tab[i].pos, dir_tab[i].typed,
                 dir_tab[i].res);
        idle_sender(pick_gap());
      end
    end

    // random: alternate fill-heavy and drain-heavy phases so the count sweeps 0..16
    for (n = 0; n < N_RANDOM; n++) begin
      fill_phase = ((n / 120) % 2) == 0;
      no_gaps    = ((n / 120) % 4) == 3;
      r = $urandom_range(0, 99);
      if (r < 4)                           op = OPC_UNUSED;
      else if (r < (fill_phase ? 50 : 20)) op = oil_pkg::OPC_APPEND;
      else if (r < (fill_phase ? 75 : 55)) op = oil_pkg::OPC_GET;
      else                                 op = oil_pkg::OPC_REMOVE;

      // removals mostly hit a stored item; a small value pool makes duplicates
      if (op == oil_pkg::OPC_REMOVE && stored_items.size() > 0 && $urandom_range(0, 3) != 0)
        val = stored_items[$urandom_range(0, stored_items.size() - 1)];
      else if ($urandom_range(0, 2) == 0)
        val = $urandom_range(0, 7);
      else
        val = $urandom;

      if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom_range(0, 16'hFFFF));
      else                           pos = POS_W'($urandom_range(0, stored_items.size()));

      send_req(op, val, pos, 1'b0, no_res);

      // now and then wait for every owed result before going on
      if (n % 400 == 399) begin
        idle_sender(1);
        while (pending_res.size() != 0) @(posedge clk);
      end else if (!no_gaps) begin
        idle_sender(pick_gap());
      end
    end

    // drain
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
